// File: rtl/core/ogmr_pkg.sv
// Shared types, constants and codes for the occupancy grid mark and raycast block.
`default_nettype none
package ogmr_pkg;
    localparam int MAX_SIDE  = 512;
    localparam int SIDE_W    = 9;
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int COORD_W   = 24;
    localparam int CELL_W    = 26;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 40;
    localparam int K_W       = 12;
    localparam int DIM_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COORD_W:0] HALF_BOX = 25'sd128;

    localparam logic [1:0] MODE_MARK  = 2'd0;
    localparam logic [1:0] MODE_RAY   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_EXCLUDED = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd3;
    localparam logic [2:0] STAT_BLOCKED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_M = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_W      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_H      = 3'd5;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] sensor_x;
        logic signed [COORD_W-1:0] sensor_y;
        logic signed [COORD_W-1:0] peer_x;
        logic signed [COORD_W-1:0] peer_y;
        logic [SIDE_W-1:0]         cell_x;
        logic [SIDE_W-1:0]         cell_y;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] cells_written;
        logic [1:0]  cell_state;
    } out_beat_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        data;
    } grid_wr_t;
endpackage
`default_nettype wire

// File: rtl/core/ogmr_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module ogmr_mul (
    input  wire logic                                  clk,
    input  wire logic signed [ogmr_pkg::MUL_W-1:0]     a,
    input  wire logic signed [ogmr_pkg::MUL_W-1:0]     b,
    output logic signed [ogmr_pkg::PROD_W-1:0]         p
);
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule
`default_nettype wire

// File: rtl/core/ogmr_grid.sv
// Occupancy cell memory: one write port, one registered read port.
`default_nettype none
module ogmr_grid (
    input  wire logic                              clk,
    input  wire ogmr_pkg::grid_wr_t                wr,
    input  wire logic [ogmr_pkg::ADDR_W-1:0]       raddr,
    output logic [1:0]                             rdata
);
    logic [1:0] mem [0:(1 << ogmr_pkg::ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/occupancy_grid_mark_and_raycast_top.sv
// Top level: sequencer for point marking, free-space ray walk and cell read.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_valid / in_stall  | in_data  (ogmr_pkg::in_beat_t)
//  out     | output    | out_valid / out_stall| out_data (ogmr_pkg::out_beat_t)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// After reset the block sweeps the cell memory to unknown, one cell a cycle;
// in_stall stays high during the sweep (config writes still land).
// From the accepting edge to a loaded result: mark runs its products on the
// shared multiplier, one check, five writes, one step to load the result, and
// skips the writes when the point is rejected; a ray runs its products, then per
// cell walked a memory read, then write and step, one more read when it walks off
// the map edge; a read reads memory, then loads the result. The block passes
// through idle before the next input beat is taken. The result sits in an output
// register so the next beat can be taken while the result waits on out_stall.
`default_nettype none
module occupancy_grid_mark_and_raycast_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire ogmr_pkg::in_beat_t                     in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output ogmr_pkg::out_beat_t                         out_data,
    input  wire logic                                   cfg_write,
    input  wire logic [ogmr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ogmr_pkg::COORD_W-1:0]           cfg_data
);
    localparam int CW = ogmr_pkg::CELL_W;
    localparam int AW = ogmr_pkg::ADDR_W;
    localparam int SW = ogmr_pkg::SIDE_W;
    localparam int XW = ogmr_pkg::ACC_W;
    localparam int KW = ogmr_pkg::K_W;
    localparam int DW = ogmr_pkg::DIM_W;

    localparam logic signed [CW-1:0] ONE_C = CW'(1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MCHK  = 4'd3;
    localparam logic [3:0] S_MARKW = 4'd4;
    localparam logic [3:0] S_RINIT = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // configuration
    logic signed [ogmr_pkg::COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [15:0]   cpm_reg, range_reg;
    logic [DW-1:0] map_w_reg, map_h_reg;

    // sequencer
    logic [3:0] state_reg, state_next;
    ogmr_pkg::in_beat_t item_reg, item_next;
    logic [2:0] mcnt_reg, mcnt_next;
    logic signed [CW-1:0] sxc_reg, sxc_next, syc_reg, syc_next;
    logic signed [CW-1:0] pxc_reg, pxc_next, pyc_reg, pyc_next;
    logic [49:0] dxx_reg, dxx_next, dyy_reg, dyy_next;
    logic [31:0] rr_reg, rr_next;
    logic signed [CW-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [CW:0] adx_reg, adx_next, ady_reg, ady_next;
    logic [KW-1:0] kx_reg, kx_next, ky_reg, ky_next;
    logic [XW-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic negx_reg, negx_next, negy_reg, negy_next;
    logic [2:0] nidx_reg, nidx_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [2:0] status_reg, status_next;
    logic [1:0] cstate_reg, cstate_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic out_valid_reg, out_valid_next;
    ogmr_pkg::out_beat_t out_reg, out_next;

    // datapath
    logic signed [ogmr_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [ogmr_pkg::PROD_W-1:0] prod;
    ogmr_pkg::grid_wr_t wr;
    logic [AW-1:0] raddr;
    logic [1:0] rdata;
    logic [DW-1:0] eff_w, eff_h;
    logic signed [ogmr_pkg::COORD_W:0] dpx, dpy, dqx, dqy;
    logic [2:0] nops;

    ogmr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
    ogmr_grid u_grid (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));

    function automatic logic in_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                    logic [DW-1:0] w, logic [DW-1:0] h);
        logic okx, oky;
        okx = !x[CW-1] && (x < $signed({{(CW-DW){1'b0}}, w}));
        oky = !y[CW-1] && (y < $signed({{(CW-DW){1'b0}}, h}));
        return okx && oky;
    endfunction

    // truncate toward zero after dropping the Q8.8 x Q15.8 fraction
    function automatic logic signed [CW-1:0] to_cell(logic signed [ogmr_pkg::PROD_W-1:0] p);
        logic [ogmr_pkg::PROD_W-1:0] mag;
        logic [CW-1:0] q;
        mag = p[ogmr_pkg::PROD_W-1] ? -p : p;
        q = mag[CW+ogmr_pkg::FRAC_W-1:ogmr_pkg::FRAC_W];
        return p[ogmr_pkg::PROD_W-1] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] x,
                                                logic signed [CW-1:0] y);
        return {y[SW-1:0], x[SW-1:0]};
    endfunction

    assign eff_w = (map_w_reg > DW'(ogmr_pkg::MAX_SIDE)) ? DW'(ogmr_pkg::MAX_SIDE) : map_w_reg;
    assign eff_h = (map_h_reg > DW'(ogmr_pkg::MAX_SIDE)) ? DW'(ogmr_pkg::MAX_SIDE) : map_h_reg;

    assign dpx = {item_reg.point_x[23], item_reg.point_x} - {item_reg.sensor_x[23], item_reg.sensor_x};
    assign dpy = {item_reg.point_y[23], item_reg.point_y} - {item_reg.sensor_y[23], item_reg.sensor_y};
    assign dqx = {item_reg.point_x[23], item_reg.point_x} - {item_reg.peer_x[23], item_reg.peer_x};
    assign dqy = {item_reg.point_y[23], item_reg.point_y} - {item_reg.peer_y[23], item_reg.peer_y};

    assign nops = (item_reg.mode == ogmr_pkg::MODE_MARK) ? 3'd7 : 3'd4;

    // operand schedule for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed({{(ogmr_pkg::MUL_W-16){1'b0}}, cpm_reg});
        case (mcnt_reg)
            3'd0: mul_a = CW'($signed({item_reg.sensor_x[23], item_reg.sensor_x}
                                      - {origin_x_reg[23], origin_x_reg}));
            3'd1: mul_a = CW'($signed({item_reg.sensor_y[23], item_reg.sensor_y}
                                      - {origin_y_reg[23], origin_y_reg}));
            3'd2: mul_a = CW'($signed({item_reg.point_x[23], item_reg.point_x}
                                      - {origin_x_reg[23], origin_x_reg}));
            3'd3: mul_a = CW'($signed({item_reg.point_y[23], item_reg.point_y}
                                      - {origin_y_reg[23], origin_y_reg}));
            3'd4:
            begin
                mul_a = CW'(dpx);
                mul_b = CW'(dpx);
            end
            3'd5:
            begin
                mul_a = CW'(dpy);
                mul_b = CW'(dpy);
            end
            3'd6:
            begin
                mul_a = $signed({{(CW-16){1'b0}}, range_reg});
                mul_b = $signed({{(CW-16){1'b0}}, range_reg});
            end
            default: mul_a = '0;
        endcase
    end

    // main sequencer
    always_comb
    begin
        logic signed [CW:0] ddx, ddy, rdx, rdy;
        logic signed [CW-1:0] nx, ny;
        logic near_end, at_end, occ, xfirst, excl;
        logic [50:0] d2;

        state_next = state_reg;   item_next = item_reg;   mcnt_next = mcnt_reg;
        sxc_next = sxc_reg;       syc_next = syc_reg;     pxc_next = pxc_reg;
        pyc_next = pyc_reg;       dxx_next = dxx_reg;     dyy_next = dyy_reg;
        rr_next = rr_reg;         gx_next = gx_reg;       gy_next = gy_reg;
        adx_next = adx_reg;       ady_next = ady_reg;     kx_next = kx_reg;
        ky_next = ky_reg;         ex_next = ex_reg;       ey_next = ey_reg;
        negx_next = negx_reg;     negy_next = negy_reg;   nidx_next = nidx_reg;
        cnt_next = cnt_reg;       status_next = status_reg;
        cstate_next = cstate_reg; clr_next = clr_reg;
        out_valid_next = out_valid_reg;  out_next = out_reg;
        wr = '0;
        raddr = cell_addr(gx_reg, gy_reg);

        ddx = {pxc_reg[CW-1], pxc_reg} - {gx_reg[CW-1], gx_reg};
        ddy = {pyc_reg[CW-1], pyc_reg} - {gy_reg[CW-1], gy_reg};
        rdx = {pxc_reg[CW-1], pxc_reg} - {sxc_reg[CW-1], sxc_reg};
        rdy = {pyc_reg[CW-1], pyc_reg} - {syc_reg[CW-1], syc_reg};
        near_end = ((ddx == 1 || ddx == -1) && ddy == 0) ||
                   (ddx == 0 && (ddy == 1 || ddy == -1));
        at_end = (ddx == 0) && (ddy == 0);
        occ = (rdata == ogmr_pkg::CELL_OCCUPIED);
        if (adx_reg == 0 && ady_reg == 0)
            xfirst = kx_reg < ky_reg;
        else if (adx_reg == 0)
            xfirst = (kx_reg == 0) && (ky_reg != 0);
        else if (ady_reg == 0)
            xfirst = ky_reg != 0;
        else
            xfirst = ex_reg < ey_reg;
        excl = (dpx > -ogmr_pkg::HALF_BOX && dpx < ogmr_pkg::HALF_BOX &&
                dpy > -ogmr_pkg::HALF_BOX && dpy < ogmr_pkg::HALF_BOX) ||
               (dqx > -ogmr_pkg::HALF_BOX && dqx < ogmr_pkg::HALF_BOX &&
                dqy > -ogmr_pkg::HALF_BOX && dqy < ogmr_pkg::HALF_BOX);
        d2 = {1'b0, dxx_reg} + {1'b0, dyy_reg};
        nx = pxc_reg;
        ny = pyc_reg;
        case (nidx_reg)
            3'd1: nx = pxc_reg - ONE_C;
            3'd2: nx = pxc_reg + ONE_C;
            3'd3: ny = pyc_reg - ONE_C;
            3'd4: ny = pyc_reg + ONE_C;
            default: nx = pxc_reg;
        endcase

        // release the result register once it has been taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr.en = 1'b1;
                wr.addr = clr_reg;
                wr.data = ogmr_pkg::CELL_UNKNOWN;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    mcnt_next = '0;
                    cnt_next = '0;
                    status_next = ogmr_pkg::STAT_DONE;
                    cstate_next = ogmr_pkg::CELL_UNKNOWN;
                    case (in_data.mode)
                        ogmr_pkg::MODE_MARK: state_next = S_MUL;
                        ogmr_pkg::MODE_RAY:  state_next = S_MUL;
                        ogmr_pkg::MODE_READ: state_next = S_RD;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:
            begin
                // issue op mcnt, capture the product of op mcnt-1
                mcnt_next = mcnt_reg + 1'b1;
                case (mcnt_reg)
                    3'd1: sxc_next = to_cell(prod);
                    3'd2: syc_next = to_cell(prod);
                    3'd3: pxc_next = to_cell(prod);
                    3'd4: pyc_next = to_cell(prod);
                    3'd5: dxx_next = prod[49:0];
                    3'd6: dyy_next = prod[49:0];
                    3'd7: rr_next = prod[31:0];
                    default: mcnt_next = mcnt_reg + 1'b1;
                endcase
                if (mcnt_reg == nops)
                    state_next = (item_reg.mode == ogmr_pkg::MODE_MARK) ? S_MCHK : S_RINIT;
            end
            S_MCHK:
            begin
                nidx_next = '0;
                if (excl)
                begin
                    status_next = ogmr_pkg::STAT_EXCLUDED;
                    state_next = S_DONE;
                end
                else if (d2 > {19'b0, rr_reg})
                begin
                    status_next = ogmr_pkg::STAT_RANGE;
                    state_next = S_DONE;
                end
                else if (!in_map(pxc_reg, pyc_reg, eff_w, eff_h))
                begin
                    status_next = ogmr_pkg::STAT_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MARKW;
                end
            end
            S_MARKW:
            begin
                // cell, then left, right, lower, upper neighbor
                if (in_map(nx, ny, eff_w, eff_h))
                begin
                    wr.en = 1'b1;
                    wr.addr = cell_addr(nx, ny);
                    wr.data = ogmr_pkg::CELL_OCCUPIED;
                    cnt_next = cnt_reg + 1'b1;
                end
                nidx_next = nidx_reg + 1'b1;
                if (nidx_reg == 3'd4)
                    state_next = S_DONE;
            end
            S_RINIT:
            begin
                negx_next = !(rdx > 0);
                negy_next = !(rdy > 0);
                adx_next = rdx[CW] ? (CW+1)'(-rdx) : rdx[CW:0];
                ady_next = rdy[CW] ? (CW+1)'(-rdy) : rdy[CW:0];
                kx_next = (rdx > 0) ? KW'(1) : '0;
                ky_next = (rdy > 0) ? KW'(1) : '0;
                // ex tracks kx*|dy|, ey tracks ky*|dx|
                ex_next = (rdx > 0) ? XW'(rdy[CW] ? -rdy : rdy) : '0;
                ey_next = (rdy > 0) ? XW'(rdx[CW] ? -rdx : rdx) : '0;
                gx_next = sxc_reg;
                gy_next = syc_reg;
                if (!in_map(sxc_reg, syc_reg, eff_w, eff_h))
                begin
                    status_next = ogmr_pkg::STAT_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (item_reg.mode == ogmr_pkg::MODE_READ)
                begin
                    raddr = {item_reg.cell_y, item_reg.cell_x};
                    if (!in_map($signed({{(CW-SW){1'b0}}, item_reg.cell_x}),
                                $signed({{(CW-SW){1'b0}}, item_reg.cell_y}), eff_w, eff_h))
                    begin
                        status_next = ogmr_pkg::STAT_OUTSIDE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
                else if (!in_map(gx_reg, gy_reg, eff_w, eff_h))
                begin
                    // walked off the map edge
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (item_reg.mode == ogmr_pkg::MODE_READ)
                begin
                    cstate_next = rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!occ)
                    begin
                        wr.en = 1'b1;
                        wr.addr = cell_addr(gx_reg, gy_reg);
                        wr.data = ogmr_pkg::CELL_FREE;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (near_end)
                        state_next = S_DONE;
                    else if (occ)
                    begin
                        status_next = ogmr_pkg::STAT_BLOCKED;
                        state_next = S_DONE;
                    end
                    else if (at_end)
                        state_next = S_DONE;
                    else
                    begin
                        state_next = S_RD;
                        if (xfirst)
                        begin
                            kx_next = kx_reg + 1'b1;
                            ex_next = ex_reg + XW'(ady_reg);
                            gx_next = negx_reg ? gx_reg - ONE_C : gx_reg + ONE_C;
                        end
                        else
                        begin
                            ky_next = ky_reg + 1'b1;
                            ey_next = ey_reg + XW'(adx_reg);
                            gy_next = negy_reg ? gy_reg - ONE_C : gy_reg + ONE_C;
                        end
                    end
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = status_reg;
                    out_next.cells_written = cnt_reg;
                    out_next.cell_state = cstate_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            cpm_reg <= 16'd853;
            range_reg <= 16'd2560;
            map_w_reg <= DW'(512);
            map_h_reg <= DW'(512);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    ogmr_pkg::REG_ORIGIN_X:    origin_x_reg <= cfg_data;
                    ogmr_pkg::REG_ORIGIN_Y:    origin_y_reg <= cfg_data;
                    ogmr_pkg::REG_CELLS_PER_M: cpm_reg <= cfg_data[15:0];
                    ogmr_pkg::REG_RANGE:       range_reg <= cfg_data[15:0];
                    ogmr_pkg::REG_MAP_W:       map_w_reg <= cfg_data[DW-1:0];
                    ogmr_pkg::REG_MAP_H:       map_h_reg <= cfg_data[DW-1:0];
                    default:                   cpm_reg <= cpm_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;     mcnt_reg <= mcnt_next;
        sxc_reg <= sxc_next;       syc_reg <= syc_next;
        pxc_reg <= pxc_next;       pyc_reg <= pyc_next;
        dxx_reg <= dxx_next;       dyy_reg <= dyy_next;     rr_reg <= rr_next;
        gx_reg <= gx_next;         gy_reg <= gy_next;
        adx_reg <= adx_next;       ady_reg <= ady_next;
        kx_reg <= kx_next;         ky_reg <= ky_next;
        ex_reg <= ex_next;         ey_reg <= ey_next;
        negx_reg <= negx_next;     negy_reg <= negy_next;
        nidx_reg <= nidx_next;     cnt_reg <= cnt_next;
        status_reg <= status_next; cstate_reg <= cstate_next;
        out_reg <= out_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_CLEAR || state_reg == S_MARKW || state_reg == S_EVAL))
        else $error("grid write outside a writing state");
    a_ray_free_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL && wr.en |-> wr.data == ogmr_pkg::CELL_FREE)
        else $error("ray wrote a non-free code");
    a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARKW |-> cnt_reg <= 11'd5)
        else $error("mark wrote more than five cells");
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the occupancy grid mark and raycast block: self-checking, random idling.
`default_nettype none
module tb;
    localparam int  CLK_HALF    = 6;
    localparam int  RESET_TICKS = 11;
    // Room for the reset sweep plus every beat as a full-map ray under heavy
    // idling, several times over.
    localparam longint CYCLE_LIMIT = 20000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    ogmr_pkg::in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    ogmr_pkg::out_beat_t out_data;
    logic      cfg_write = 1'b0;
    logic [ogmr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ogmr_pkg::COORD_W-1:0]   cfg_data = '0;

    occupancy_grid_mark_and_raycast_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the map registers and the cell array.
    longint    org_x_q, org_y_q, cpm_q, range_q, width_q, height_q;
    logic [1:0] grid_q [0:ogmr_pkg::MAX_SIDE*ogmr_pkg::MAX_SIDE-1];

    ogmr_pkg::in_beat_t  pending_beats [$];
    ogmr_pkg::out_beat_t expected_beats [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        mismatch_seen = 1'b0;
    longint    cycle_count = 0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------
    function automatic longint eff_width();
        return (width_q > ogmr_pkg::MAX_SIDE) ? ogmr_pkg::MAX_SIDE : width_q;
    endfunction

    function automatic longint eff_height();
        return (height_q > ogmr_pkg::MAX_SIDE) ? ogmr_pkg::MAX_SIDE : height_q;
    endfunction

    function automatic bit on_map(longint x, longint y);
        return x >= 0 && x < eff_width() && y >= 0 && y < eff_height();
    endfunction

    // Scale to cells and truncate toward zero.
    function automatic longint cell_index(longint coord, longint org);
        longint p;
        p = (coord - org) * cpm_q;
        if (p < 0)
            return -((-p) >>> 16);
        return p >>> 16;
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // tMaxX < tMaxY on exact rationals; a zero delta means an infinite step.
    function automatic bit step_x_next(longint kx, longint ky, longint adx, longint ady);
        if (adx == 0 && ady == 0)
            return kx < ky;
        if (adx == 0)
            return kx == 0 && ky > 0;
        if (ady == 0)
            return ky > 0;
        return kx * ady < ky * adx;
    endfunction

    function automatic void free_cell(longint x, longint y, ref logic [10:0] cnt);
        if (grid_q[y*ogmr_pkg::MAX_SIDE + x] != ogmr_pkg::CELL_OCCUPIED)
        begin
            grid_q[y*ogmr_pkg::MAX_SIDE + x] = ogmr_pkg::CELL_FREE;
            cnt++;
        end
    endfunction

    function automatic logic [2:0] mark_hit(ogmr_pkg::in_beat_t b, ref logic [10:0] cnt);
        longint px, py, dx, dy, gx, gy, nx, ny;
        longint offs_x [5] = '{0, -1, 1, 0, 0};
        longint offs_y [5] = '{0, 0, 0, -1, 1};
        px = b.point_x;
        py = b.point_y;
        dx = px - longint'(b.sensor_x);
        dy = py - longint'(b.sensor_y);
        if ((abs_l(dx) < ogmr_pkg::HALF_BOX && abs_l(dy) < ogmr_pkg::HALF_BOX) ||
            (abs_l(px - b.peer_x) < ogmr_pkg::HALF_BOX &&
             abs_l(py - b.peer_y) < ogmr_pkg::HALF_BOX))
            return ogmr_pkg::STAT_EXCLUDED;
        if (dx*dx + dy*dy > range_q*range_q)
            return ogmr_pkg::STAT_RANGE;
        gx = cell_index(px, org_x_q);
        gy = cell_index(py, org_y_q);
        if (!on_map(gx, gy))
            return ogmr_pkg::STAT_OUTSIDE;
        for (int i = 0; i < 5; i++)
        begin
            nx = gx + offs_x[i];
            ny = gy + offs_y[i];
            if (on_map(nx, ny))
            begin
                grid_q[ny*ogmr_pkg::MAX_SIDE + nx] = ogmr_pkg::CELL_OCCUPIED;
                cnt++;
            end
        end
        return ogmr_pkg::STAT_DONE;
    endfunction

    function automatic logic [2:0] cast_ray(ogmr_pkg::in_beat_t b, ref logic [10:0] cnt);
        longint x0, y0, x1, y1, dx, dy, stx, sty, kx, ky, gx, gy;
        x0 = cell_index(b.sensor_x, org_x_q);
        y0 = cell_index(b.sensor_y, org_y_q);
        x1 = cell_index(b.point_x, org_x_q);
        y1 = cell_index(b.point_y, org_y_q);
        dx = x1 - x0;
        dy = y1 - y0;
        stx = (dx > 0) ? 1 : -1;
        sty = (dy > 0) ? 1 : -1;
        kx = (dx > 0) ? 1 : 0;
        ky = (dy > 0) ? 1 : 0;
        gx = x0;
        gy = y0;
        if (!on_map(x0, y0))
            return ogmr_pkg::STAT_OUTSIDE;
        free_cell(x0, y0, cnt);
        forever
        begin
            if ((abs_l(gx - x1) == 1 && gy == y1) || (gx == x1 && abs_l(gy - y1) == 1))
                return ogmr_pkg::STAT_DONE;
            if (grid_q[gy*ogmr_pkg::MAX_SIDE + gx] == ogmr_pkg::CELL_OCCUPIED)
                return ogmr_pkg::STAT_BLOCKED;
            if (gx == x1 && gy == y1)
                return ogmr_pkg::STAT_DONE;
            if (step_x_next(kx, ky, abs_l(dx), abs_l(dy)))
            begin
                kx++;
                gx += stx;
            end
            else
            begin
                ky++;
                gy += sty;
            end
            if (!on_map(gx, gy))
                return ogmr_pkg::STAT_DONE;
            free_cell(gx, gy, cnt);
        end
    endfunction

    function automatic ogmr_pkg::out_beat_t grid_response(ogmr_pkg::in_beat_t b);
        ogmr_pkg::out_beat_t r;
        logic [10:0] cnt;
        r   = '0;
        cnt = '0;
        case (b.mode)
            ogmr_pkg::MODE_MARK: r.status = mark_hit(b, cnt);
            ogmr_pkg::MODE_RAY:  r.status = cast_ray(b, cnt);
            ogmr_pkg::MODE_READ:
            begin
                if (on_map(b.cell_x, b.cell_y))
                    r.cell_state = grid_q[b.cell_y*ogmr_pkg::MAX_SIDE + b.cell_x];
                else
                    r.status = ogmr_pkg::STAT_OUTSIDE;
            end
            default: ;
        endcase
        r.cells_written = cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued beats, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic accepted;
        accepted = in_valid && !in_stall;
        if (accepted)
            expected_beats.insert(expected_beats.size(), grid_response(in_data));
        // Hold a stalled beat; otherwise advance or idle.
        if (rst_n && (!in_valid || accepted))
        begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data  <= pending_beats[0];
                pending_beats.delete(0);
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: compare each delivered beat with the oldest prediction.
    always @(posedge clk)
    begin
        ogmr_pkg::out_beat_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat %p", out_data);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = expected_beats[0];
                expected_beats.delete(0);
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    mismatch_seen = 1'b1;
                end
                if (out_data.cells_written !== want.cells_written)
                begin
                    $error("cells_written: expected %0d, got %0d",
                           want.cells_written, out_data.cells_written);
                    mismatch_seen = 1'b1;
                end
                if (out_data.cell_state !== want.cell_state)
                begin
                    $error("cell_state: expected %0d, got %0d",
                           want.cell_state, out_data.cell_state);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void enqueue_beat(ogmr_pkg::in_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    task automatic write_reg(logic [ogmr_pkg::CFG_IDX_W-1:0] idx, longint value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ogmr_pkg::COORD_W-1:0];
        case (idx)
            ogmr_pkg::REG_ORIGIN_X:    org_x_q  = longint'($signed(value[ogmr_pkg::COORD_W-1:0]));
            ogmr_pkg::REG_ORIGIN_Y:    org_y_q  = longint'($signed(value[ogmr_pkg::COORD_W-1:0]));
            ogmr_pkg::REG_CELLS_PER_M: cpm_q    = value & 16'hFFFF;
            ogmr_pkg::REG_RANGE:       range_q  = value & 16'hFFFF;
            ogmr_pkg::REG_MAP_W:       width_q  = value & 10'h3FF;
            ogmr_pkg::REG_MAP_H:       height_q = value & 10'h3FF;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_map(longint ox, longint oy, longint cpm, longint rng,
                           longint w, longint h);
        write_reg(ogmr_pkg::REG_ORIGIN_X, ox);
        write_reg(ogmr_pkg::REG_ORIGIN_Y, oy);
        write_reg(ogmr_pkg::REG_CELLS_PER_M, cpm);
        write_reg(ogmr_pkg::REG_RANGE, rng);
        write_reg(ogmr_pkg::REG_MAP_W, w);
        write_reg(ogmr_pkg::REG_MAP_H, h);
    endtask

    function automatic ogmr_pkg::in_beat_t make_beat(logic [1:0] mode, longint px, longint py,
                                           longint sx, longint sy, longint qx, longint qy,
                                           int cx, int cy);
        ogmr_pkg::in_beat_t b;
        b.mode     = mode;
        b.point_x  = px[ogmr_pkg::COORD_W-1:0];
        b.point_y  = py[ogmr_pkg::COORD_W-1:0];
        b.sensor_x = sx[ogmr_pkg::COORD_W-1:0];
        b.sensor_y = sy[ogmr_pkg::COORD_W-1:0];
        b.peer_x   = qx[ogmr_pkg::COORD_W-1:0];
        b.peer_y   = qy[ogmr_pkg::COORD_W-1:0];
        b.cell_x   = cx[ogmr_pkg::SIDE_W-1:0];
        b.cell_y   = cy[ogmr_pkg::SIDE_W-1:0];
        return b;
    endfunction

    // Raw coordinate near the middle of cell c.
    function automatic longint cell_mid(longint c, longint org);
        return org + (c * 65536) / cpm_q + (65536 / cpm_q) / 2;
    endfunction

    function automatic longint spread(longint m);
        return longint'($urandom_range(0, 2*m)) - m;
    endfunction

    function automatic longint coord_on_map(longint org, longint cells);
        longint span;
        span = cells * 65536 / cpm_q;
        return org - span/16 + longint'($urandom_range(0, span + span/8));
    endfunction

    function automatic ogmr_pkg::in_beat_t random_beat();
        longint cw, sx, sy, px, py, qx, qy, reach;
        int     pick;
        cw   = 65536 / cpm_q;
        pick = $urandom_range(0, 99);
        sx   = coord_on_map(org_x_q, eff_width());
        sy   = coord_on_map(org_y_q, eff_height());
        qx   = coord_on_map(org_x_q, eff_width());
        qy   = coord_on_map(org_y_q, eff_height());
        if (pick < 35)
        begin
            reach = range_q * 5 / 4 + 200;
            px = sx + spread(reach);
            py = sy + spread(reach);
            if ($urandom_range(0, 99) < 15)
            begin
                qx = px + spread(160);
                qy = py + spread(160);
            end
            return make_beat(ogmr_pkg::MODE_MARK, px, py, sx, sy, qx, qy, 0, 0);
        end
        if (pick < 75)
        begin
            // Keep most rays short; a few cross the map.
            if ($urandom_range(0, 99) < 8)
            begin
                px = coord_on_map(org_x_q, eff_width());
                py = coord_on_map(org_y_q, eff_height());
            end
            else
            begin
                px = sx + spread(30) * cw + spread(cw);
                py = sy + spread(30) * cw + spread(cw);
            end
            return make_beat(ogmr_pkg::MODE_RAY, px, py, sx, sy, qx, qy, 0, 0);
        end
        if (pick < 90)
        begin
            if ($urandom_range(0, 4) == 0 || eff_width() == 0 || eff_height() == 0)
                return make_beat(ogmr_pkg::MODE_READ, sx, sy, qx, qy, px, py,
                                 int'($urandom_range(0, 511)), int'($urandom_range(0, 511)));
            return make_beat(ogmr_pkg::MODE_READ, sx, sy, qx, qy, sx, sy,
                             int'($urandom_range(0, 32'(eff_width() - 1))),
                             int'($urandom_range(0, 32'(eff_height() - 1))));
        end
        // Noise: every field fully random, unused mode included.
        return make_beat(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, int'($urandom), int'($urandom));
    endfunction

    task automatic load_directed();
        longint far_away;
        far_away = -8388608;
        // Exclusion around the sensor, then around the peer.
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(10, 0), cell_mid(10, 0),
            cell_mid(10, 0) + 127, cell_mid(10, 0) - 127, far_away, far_away, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(10, 0), cell_mid(10, 0),
            cell_mid(10, 0) + 1000, cell_mid(10, 0), cell_mid(10, 0) - 127,
            cell_mid(10, 0) + 127, 0, 0));
        // Range: just beyond, then exactly on the limit.
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(100, 0) + 2561,
            cell_mid(100, 0), cell_mid(100, 0), cell_mid(100, 0), far_away, far_away, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(100, 0) + 2560,
            cell_mid(100, 0), cell_mid(100, 0), cell_mid(100, 0), far_away, far_away, 0, 0));
        // Outside the map, then both corners with clipped neighbours.
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, -500, 300, 500, 300,
            far_away, far_away, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(0, 0), cell_mid(0, 0),
            cell_mid(0, 0) + 1000, cell_mid(0, 0), far_away, far_away, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, cell_mid(511, 0), cell_mid(511, 0),
            cell_mid(511, 0) - 1000, cell_mid(511, 0), far_away, far_away, 0, 0));
        // Field extremes.
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, 8388607, 8388607, -8388608, -8388608,
            -8388608, 8388607, 511, 511));
        enqueue_beat(make_beat(ogmr_pkg::MODE_MARK, -8388608, -8388608, 8388607, 8388607,
            8388607, -8388608, 0, 0));
        // Rays: ordinary, blocked by the mark above, zero length, off the edge,
        // start off the map, diagonal ties, and zero x delta.
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(40, 0), cell_mid(30, 0),
            cell_mid(20, 0), cell_mid(20, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(15, 0), cell_mid(10, 0),
            cell_mid(5, 0), cell_mid(10, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(50, 0), cell_mid(50, 0),
            cell_mid(50, 0), cell_mid(50, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, -20000, cell_mid(200, 0),
            cell_mid(2, 0), cell_mid(200, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(3, 0), cell_mid(3, 0),
            -3000, cell_mid(3, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(110, 0), cell_mid(110, 0),
            cell_mid(100, 0), cell_mid(100, 0), 0, 0, 0, 0));
        enqueue_beat(make_beat(ogmr_pkg::MODE_RAY, cell_mid(300, 0), cell_mid(320, 0),
            cell_mid(300, 0), cell_mid(300, 0), 0, 0, 0, 0));
        // Reads of occupied, free and unknown cells.
        enqueue_beat(make_beat(ogmr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 10, 10));
        enqueue_beat(make_beat(ogmr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 25, 22));
        enqueue_beat(make_beat(ogmr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 400, 400));
        enqueue_beat(make_beat(ogmr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 511, 511));
        enqueue_beat(make_beat(ogmr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        // Unused mode with all fields at both extremes.
        enqueue_beat(make_beat(ogmr_pkg::MODE_SPARE, -1, -1, -1, -1, -1, -1, 511, 511));
        enqueue_beat(make_beat(ogmr_pkg::MODE_SPARE, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0);
        // Every beat yields one result, so a short settle is enough.
        repeat (20) @(posedge clk);
    endtask

    task automatic run_phase(int beats, int snd_pct, int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < beats; i++)
            enqueue_beat(random_beat());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        org_x_q  = 0;
        org_y_q  = 0;
        cpm_q    = 853;
        range_q  = 2560;
        width_q  = 512;
        height_q = 512;
        foreach (grid_q[i])
            grid_q[i] = ogmr_pkg::CELL_UNKNOWN;

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values; the block still sweeps its memory, so beats wait.
        load_directed();
        run_phase(300, 0, 0);

        set_map(-5000, 3000, 4096, 1000, 64, 48);
        run_phase(320, 88, 0);

        // Finest grid, widest range, oversized map.
        set_map(0, 0, 65535, 65535, 1023, 1023);
        run_phase(320, 0, 88);

        // Coarsest grid, zero range, empty map.
        set_map(8388607, -8388608, 1, 0, 0, 0);
        run_phase(150, 17, 17);

        set_map(-8388608, 8388607, 1, 65535, 7, 512);
        run_phase(300, 17, 17);

        set_map(1000, -2000, 853, 2560, 1, 512);
        run_phase(200, 88, 88);

        set_map(0, 0, 853, 2560, 512, 512);
        run_phase(250, 0, 0);

        if (!mismatch_seen)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
